@@ rtl/lcs_pkg.sv @@
// Shared types and constants of the Laplacian color sharpening pipeline.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package lcs_pkg;

    localparam int PIX_W = 8;
    localparam int RGB_W = 24;
    localparam int COL_W = 11;
    localparam int ROW_W = 12;
    localparam int CFG_W = 12;
    localparam int STR_W = 4;
    localparam int IDX_W = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_IDX_STRENGTH = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_WIDTH    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd2;

    // Configuration values after reset.
    localparam logic [STR_W-1:0] STRENGTH_RST = 4'd1;
    localparam logic [CFG_W-1:0] WIDTH_RST    = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST   = 12'd480;

    // Output queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Position and classification of one pixel.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             interior;
        logic             border;
    } t_pos;

    // One result word.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } t_result;

    // Up to two result words caused by one pixel, sharpened word first.
    typedef struct packed {
        logic    int_en;
        logic    bord_en;
        t_result int_res;
        t_result bord_res;
    } t_pair;

endpackage

`default_nettype wire

@@ rtl/lcs_pos.sv @@
// Raster position tracker: column and row counters with frame wrap.
// Depends on lcs_pkg for widths and the position struct.
`default_nettype none

module lcs_pos #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_waiting,
    input  wire logic                           i_sof,
    input  wire logic                           i_cfg_wr,
    input  wire logic [lcs_pkg::CFG_W-1:0]      i_frame_width,
    input  wire logic [lcs_pkg::CFG_W-1:0]      i_frame_height,
    output logic                                o_hold,
    output lcs_pkg::t_pos                       o_pos,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_addr
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = AW + 1;
    localparam int EW_W = (CW > lcs_pkg::CFG_W) ? CW : lcs_pkg::CFG_W;

    logic [CW-1:0]             r_col, n_col, rw_col, p_col, step_col, ew;
    logic [lcs_pkg::ROW_W-1:0] r_row, n_row, rw_row, p_row, step_row, eh;
    logic [EW_W-1:0]           fw_x, ew_x;
    logic                      r_rewrap, n_rewrap, do_rewrap, last_col, last_row;

    always_comb begin
        fw_x = EW_W'(i_frame_width);
        if (i_frame_width == '0) begin
            ew_x = EW_W'(1);
        end else if (fw_x > EW_W'(MAX_WIDTH)) begin
            ew_x = EW_W'(MAX_WIDTH);
        end else begin
            ew_x = fw_x;
        end
        ew = CW'(ew_x);
        eh = (i_frame_height == '0) ? lcs_pkg::ROW_W'(1) : i_frame_height;

        // Re-fit the held position after the frame size changed.
        rw_col = r_col;
        rw_row = r_row;
        if (r_col >= ew) begin
            rw_col = '0;
            rw_row = r_row + 1'b1;
        end
        if (rw_row >= eh) begin
            rw_row = '0;
        end

        p_col    = i_sof ? '0 : r_col;
        p_row    = i_sof ? '0 : r_row;
        last_col = (p_col == ew - 1'b1);
        last_row = (p_row == eh - 1'b1);

        if (last_col) begin
            step_col = '0;
            step_row = last_row ? '0 : p_row + 1'b1;
        end else begin
            step_col = p_col + 1'b1;
            step_row = p_row;
        end

        do_rewrap = r_rewrap & i_waiting & ~i_cfg_wr;

        if (i_accept) begin
            n_col = step_col;
            n_row = step_row;
        end else if (do_rewrap) begin
            n_col = rw_col;
            n_row = rw_row;
        end else begin
            n_col = r_col;
            n_row = r_row;
        end

        if (i_cfg_wr) begin
            n_rewrap = 1'b1;
        end else if (do_rewrap) begin
            n_rewrap = 1'b0;
        end else begin
            n_rewrap = r_rewrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_rewrap <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_rewrap <= n_rewrap;
        end
    end

    assign o_hold         = r_rewrap;
    assign o_pos.col      = lcs_pkg::COL_W'(p_col);
    assign o_pos.row      = p_row;
    assign o_pos.interior = (p_col >= CW'(2)) && (p_row >= lcs_pkg::ROW_W'(2));
    assign o_pos.border   = (p_col == '0) || (p_row == '0) || last_col || last_row;
    assign o_addr         = p_col[AW-1:0];

endmodule

`default_nettype wire

@@ rtl/lcs_linebuf.sv @@
// Two line stores holding the previous two rows, with write-to-read forwarding.
// Depends on lcs_pkg for the pixel width.
`default_nettype none

module lcs_linebuf #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]   i_rd_addr,
    input  wire logic                           i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]   i_wr_addr,
    input  wire logic [lcs_pkg::RGB_W-1:0]      i_wr_pix,
    output logic [lcs_pkg::RGB_W-1:0]           o_above,
    output logic [lcs_pkg::RGB_W-1:0]           o_two_above
);

    logic [lcs_pkg::RGB_W-1:0] r_above_mem [MAX_WIDTH];
    logic [lcs_pkg::RGB_W-1:0] r_two_mem   [MAX_WIDTH];
    logic [lcs_pkg::RGB_W-1:0] r_rd_above, r_rd_two, r_fwd_above, r_fwd_two;
    logic                      r_fwd;

    // The row above moves down to the row two above as the new pixel lands.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_above_mem[i_wr_addr] <= i_wr_pix;
            r_two_mem[i_wr_addr]   <= o_above;
        end
        if (i_rd_en) begin
            r_rd_above  <= r_above_mem[i_rd_addr];
            r_rd_two    <= r_two_mem[i_rd_addr];
            r_fwd_above <= i_wr_pix;
            r_fwd_two   <= o_above;
        end
    end

    // A read of the column being written in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_above     = r_fwd ? r_fwd_above : r_rd_above;
    assign o_two_above = r_fwd ? r_fwd_two : r_rd_two;

endmodule

`default_nettype wire

@@ rtl/lcs_sharpen.sv @@
// 3x3 window and three arithmetic stages: neighbor difference, strength
// product, then sum and clamp. Depends on lcs_pkg.
`default_nettype none

module lcs_sharpen (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  lcs_pkg::t_pos                      i_pos,
    input  wire logic [lcs_pkg::RGB_W-1:0]     i_pix,
    input  wire logic [lcs_pkg::RGB_W-1:0]     i_above,
    input  wire logic [lcs_pkg::RGB_W-1:0]     i_two_above,
    input  wire logic [lcs_pkg::STR_W-1:0]     i_strength,
    output logic                               o_valid,
    output lcs_pkg::t_pair                     o_pair
);

    localparam int PW = lcs_pkg::PIX_W;

    logic [lcs_pkg::RGB_W-1:0] r_win_top [3];
    logic [lcs_pkg::RGB_W-1:0] r_win_mid [3];
    logic [lcs_pkg::RGB_W-1:0] r_win_bot [3];

    logic                      r_s2_v, r_s3_v, r_s4_v;
    lcs_pkg::t_pos             r_s2_pos, r_s3_pos, r_s4_pos;
    logic [lcs_pkg::RGB_W-1:0] r_s3_pix, r_s4_pix;
    logic signed [11:0]        r_s3_d [3];
    logic [PW-1:0]             r_s3_c [3];
    logic signed [15:0]        r_s4_prod [3];
    logic [PW-1:0]             r_s4_c [3];

    logic signed [11:0]        d [3];
    logic signed [15:0]        prod [3];
    logic [lcs_pkg::RGB_W-1:0] sharp;

    // Window columns shift left as each pixel arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_win_top[i] <= '0;
                r_win_mid[i] <= '0;
                r_win_bot[i] <= '0;
            end
        end else if (i_en && i_valid) begin
            for (int i = 0; i < 2; i++) begin
                r_win_top[i] <= r_win_top[i+1];
                r_win_mid[i] <= r_win_mid[i+1];
                r_win_bot[i] <= r_win_bot[i+1];
            end
            r_win_top[2] <= i_two_above;
            r_win_mid[2] <= i_above;
            r_win_bot[2] <= i_pix;
        end
    end

    // Per channel: the centre shifted left by two bits, less the sum of its north, south, west and east neighbors.
    always_comb begin
        logic [PW-1:0] cen;
        logic [9:0]    nsum;
        cen  = '0;
        nsum = '0;
        for (int ch = 0; ch < 3; ch++) begin
            cen  = r_win_mid[1][ch*PW +: PW];
            nsum = 10'(r_win_top[1][ch*PW +: PW]) + 10'(r_win_bot[1][ch*PW +: PW])
                 + 10'(r_win_mid[0][ch*PW +: PW]) + 10'(r_win_mid[2][ch*PW +: PW]);
            d[ch] = $signed({2'b00, cen, 2'b00}) - $signed({2'b00, nsum});
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = $signed({12'b0, i_strength}) * 16'(r_s3_d[ch]);
        end
    end

    // Centre plus strength times difference, clamped to the pixel range.
    always_comb begin
        logic signed [15:0] v;
        v = '0;
        for (int ch = 0; ch < 3; ch++) begin
            v = $signed({8'b0, r_s4_c[ch]}) + r_s4_prod[ch];
            if (v < 16'sd0) begin
                sharp[ch*PW +: PW] = '0;
            end else if (v > 16'sd255) begin
                sharp[ch*PW +: PW] = '1;
            end else begin
                sharp[ch*PW +: PW] = v[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (i_en) begin
            r_s2_v <= i_valid;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_pos <= i_pos;
            r_s3_pos <= r_s2_pos;
            r_s3_pix <= r_win_bot[2];
            r_s4_pos <= r_s3_pos;
            r_s4_pix <= r_s3_pix;
            for (int ch = 0; ch < 3; ch++) begin
                r_s3_d[ch]    <= d[ch];
                r_s3_c[ch]    <= r_win_mid[1][ch*PW +: PW];
                r_s4_prod[ch] <= prod[ch];
                r_s4_c[ch]    <= r_s3_c[ch];
            end
        end
    end

    always_comb begin
        o_pair.int_en         = r_s4_pos.interior;
        o_pair.bord_en        = r_s4_pos.border;
        o_pair.int_res.col    = r_s4_pos.col - 1'b1;
        o_pair.int_res.row    = r_s4_pos.row - 1'b1;
        o_pair.int_res.red    = sharp[2*PW +: PW];
        o_pair.int_res.green  = sharp[PW +: PW];
        o_pair.int_res.blue   = sharp[0 +: PW];
        o_pair.int_res.last   = ~r_s4_pos.border;
        o_pair.bord_res.col   = r_s4_pos.col;
        o_pair.bord_res.row   = r_s4_pos.row;
        o_pair.bord_res.red   = r_s4_pix[2*PW +: PW];
        o_pair.bord_res.green = r_s4_pix[PW +: PW];
        o_pair.bord_res.blue  = r_s4_pix[0 +: PW];
        o_pair.bord_res.last  = 1'b1;
    end

    assign o_valid = r_s4_v;

endmodule

`default_nettype wire

@@ rtl/lcs_outq.sv @@
// Small output queue that takes up to two result words per cycle and
// hands out one while i_ready is high. Depends on lcs_pkg for the result types and depth.
`default_nettype none

module lcs_outq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  lcs_pkg::t_pair   i_pair,
    output logic             o_room,
    output logic             o_valid,
    output lcs_pkg::t_result o_res,
    input  wire logic        i_ready
);

    lcs_pkg::t_result             r_q [lcs_pkg::OQ_DEPTH];
    logic [lcs_pkg::OQ_AW-1:0]    r_wp, r_rp, bord_wp;
    logic [lcs_pkg::OQ_CW-1:0]    r_cnt, push_n;
    logic                         pop;

    always_comb begin
        push_n  = i_push ? lcs_pkg::OQ_CW'(i_pair.int_en) + lcs_pkg::OQ_CW'(i_pair.bord_en)
                         : '0;
        bord_wp = r_wp + lcs_pkg::OQ_AW'(i_pair.int_en);
        pop     = o_valid & i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_pair.int_en) begin
                r_q[r_wp] <= i_pair.int_res;
            end
            if (i_pair.bord_en) begin
                r_q[bord_wp] <= i_pair.bord_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + lcs_pkg::OQ_AW'(push_n);
            r_rp  <= r_rp + lcs_pkg::OQ_AW'(pop);
            r_cnt <= r_cnt + push_n - lcs_pkg::OQ_CW'(pop);
        end
    end

    // Room for a full pair is required before a valid last stage may advance.
    assign o_room  = (r_cnt <= lcs_pkg::OQ_CW'(lcs_pkg::OQ_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[r_rp];

endmodule

`default_nettype wire

@@ rtl/laplacian_color_sharpen_top.sv @@
// Streaming 3x3 Laplacian sharpening of RGB pixels; uses lcs_pkg, lcs_pos, lcs_linebuf,
// lcs_sharpen and lcs_outq. Throughput is one pixel per clock unless the output stalls or
// the position re-fits. A pixel from column and row two on in the last column or last row
// yields two words; the first passes stage one, window, difference, product and the output
// queue, the second follows. After any configuration write the first pixel waits for the
// position to re-fit. Reset clears control and restores the registers; line stores are not.
`default_nettype none

module laplacian_color_sharpen_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Pixel input channel.
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_start_of_frame,
    input  wire logic [lcs_pkg::PIX_W-1:0]     i_red_in,
    input  wire logic [lcs_pkg::PIX_W-1:0]     i_green_in,
    input  wire logic [lcs_pkg::PIX_W-1:0]     i_blue_in,
    // Result output channel.
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [lcs_pkg::COL_W-1:0]          o_out_column,
    output logic [lcs_pkg::ROW_W-1:0]          o_out_row,
    output logic [lcs_pkg::PIX_W-1:0]          o_red_out,
    output logic [lcs_pkg::PIX_W-1:0]          o_green_out,
    output logic [lcs_pkg::PIX_W-1:0]          o_blue_out,
    output logic                               o_last_for_input,
    // Configuration write channel.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lcs_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [lcs_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Configuration registers. Writes are always taken; the user must make them only
    // while no pixel is in flight, which the block itself does not enforce.
    logic [lcs_pkg::STR_W-1:0] r_strength;
    logic [lcs_pkg::CFG_W-1:0] r_frame_width, r_frame_height;
    logic                      cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength     <= lcs_pkg::STRENGTH_RST;
            r_frame_width  <= lcs_pkg::WIDTH_RST;
            r_frame_height <= lcs_pkg::HEIGHT_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                lcs_pkg::CFG_IDX_STRENGTH: begin
                    r_strength <= i_cfg_data[lcs_pkg::STR_W-1:0];
                end
                lcs_pkg::CFG_IDX_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                lcs_pkg::CFG_IDX_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together. It advances whenever the last
    // stage is empty or the output queue has room for a full pair of words,
    // so a stall at the output freezes every stage and loses nothing.
    logic                      en, acc, pos_hold, s4_v, oq_room;
    lcs_pkg::t_pos             pos;
    logic [AW-1:0]             pos_addr;
    lcs_pkg::t_pair            pair;
    lcs_pkg::t_result          oq_res;

    assign en      = ~s4_v | oq_room;
    assign o_ready = en & ~pos_hold;
    assign acc     = i_valid & o_ready;

    lcs_pos #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (acc),
        .i_waiting      (i_valid),
        .i_sof          (i_start_of_frame),
        .i_cfg_wr       (cfg_acc),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_hold         (pos_hold),
        .o_pos          (pos),
        .o_addr         (pos_addr)
    );

    // Stage one: the accepted pixel and its position, while the line
    // stores are read at its column.
    logic                      r_s1_v;
    lcs_pkg::t_pos             r_s1_pos;
    logic [lcs_pkg::RGB_W-1:0] r_s1_pix;
    logic [AW-1:0]             r_s1_addr;
    logic [lcs_pkg::RGB_W-1:0] above, two_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pos  <= pos;
            r_s1_pix  <= {i_red_in, i_green_in, i_blue_in};
            r_s1_addr <= pos_addr;
        end
    end

    // The pixel in stage one writes its column as it leaves, and the old
    // row-above entry moves to the row-two-above store.
    lcs_linebuf #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_linebuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (acc),
        .i_rd_addr   (pos_addr),
        .i_wr_en     (en & r_s1_v),
        .i_wr_addr   (r_s1_addr),
        .i_wr_pix    (r_s1_pix),
        .o_above     (above),
        .o_two_above (two_above)
    );

    // Stages two to four: window, difference, product, clamp.
    lcs_sharpen u_sharpen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_s1_v),
        .i_pos       (r_s1_pos),
        .i_pix       (r_s1_pix),
        .i_above     (above),
        .i_two_above (two_above),
        .i_strength  (r_strength),
        .o_valid     (s4_v),
        .o_pair      (pair)
    );

    // The sharpened word of the pixel centred one row up and one column
    // left goes into the queue ahead of the pass-through word of a border
    // pixel, so the order of words matches the arrival order of causes.
    lcs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en & s4_v),
        .i_pair  (pair),
        .o_room  (oq_room),
        .o_valid (o_valid),
        .o_res   (oq_res),
        .i_ready (i_ready)
    );

    assign o_out_column     = oq_res.col;
    assign o_out_row        = oq_res.row;
    assign o_red_out        = oq_res.red;
    assign o_green_out      = oq_res.green;
    assign o_blue_out       = oq_res.blue;
    assign o_last_for_input = oq_res.last;

    // A frozen pipeline keeps its last stage occupied.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> s4_v)
        else $error("last stage emptied while the pipeline was stalled");

    // Any configuration write makes the position tracker re-fit before
    // the next pixel is taken.
    a_cfg_refit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (pos_hold && !acc))
        else $error("pixel accepted right after a configuration write");

    // A word that is not the last of its pixel has its partner queued.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_for_input) |=> o_valid)
        else $error("second word of a pixel missing from the output queue");

endmodule

`default_nettype wire
